@@ sv/e820_pkg.sv @@
// ============================================================================
// e820_pkg
// Shared types, class codes and the UEFI type to E820 class mapping.
// ============================================================================
`default_nettype none

package e820_pkg;

  // E820 class codes
  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_RAM      = 3'd1;
  localparam logic [2:0] CLS_RESERVED = 3'd2;
  localparam logic [2:0] CLS_ACPI     = 3'd3;
  localparam logic [2:0] CLS_NVS      = 3'd4;
  localparam logic [2:0] CLS_UNUSABLE = 3'd5;

  // Page size shift (4 KiB pages)
  localparam int PAGE_SHIFT = 12;

  // Width of the entry total field
  localparam int TOTAL_W = 6;

  // One table entry as held in the table memory
  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] len;
    logic [2:0]  cls;
  } e820_entry_t;

  // One result of the finish run
  typedef struct packed {
    e820_entry_t          entry;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
    logic                 empty;
  } e820_res_t;

  // UEFI memory type to E820 class; CLS_NONE means skip
  function automatic logic [2:0] e820_class(input logic [31:0] mem_type);
    logic [2:0] cls;
    cls = CLS_NONE;
    unique case (mem_type)
      32'd0, 32'd11, 32'd12, 32'd13:                 cls = CLS_RESERVED;
      32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
      32'd14:                                        cls = CLS_RAM;
      32'd8:                                         cls = CLS_UNUSABLE;
      32'd9:                                         cls = CLS_ACPI;
      32'd10:                                        cls = CLS_NVS;
      default:                                       cls = CLS_NONE;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ sv/e820_mem.sv @@
// ============================================================================
// e820_mem
// Entry table: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module e820_mem
  import e820_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [AW-1:0] waddr,
  input  wire e820_entry_t wdata,
  input  wire logic [AW-1:0] raddr,
  output e820_entry_t      rdata
);

  e820_entry_t mem [DEPTH];
  e820_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/e820_sort.sv @@
// ============================================================================
// e820_sort
// Finish sequencer: exchange sort over the table memory, emitting each entry
// as soon as its slot is settled, then requesting a table clear.
// ============================================================================
`default_nettype none

module e820_sort
  import e820_pkg::*;
#(
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [CW-1:0] count,
  output logic               busy,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output e820_entry_t        wdata,
  output logic [AW-1:0]      raddr,
  input  wire e820_entry_t   rdata,
  output logic               res_valid,
  output e820_res_t          res,
  output logic               clr
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD_I = 3'd1;
  localparam logic [2:0] ST_LD_I = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          empty_r, empty_nxt;
  e820_entry_t   cur_r, cur_nxt;
  logic [CW-1:0] i_inc, j_inc;
  logic          is_last;

  assign i_inc   = i_r + 1'b1;
  assign j_inc   = j_r + 1'b1;
  assign is_last = empty_r || (i_inc == n_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    empty_nxt = empty_r;
    cur_nxt   = cur_r;
    we        = 1'b0;
    waddr     = j_r[AW-1:0];
    wdata     = cur_r;
    raddr     = i_r[AW-1:0];
    clr       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          n_nxt     = count;
          i_nxt     = '0;
          empty_nxt = (count == '0);
          cur_nxt   = '0;
          state_nxt = (count == '0) ? ST_EMIT : ST_RD_I;
        end
      end
      ST_RD_I: begin
        raddr     = i_r[AW-1:0];
        state_nxt = ST_LD_I;
      end
      ST_LD_I: begin
        // hold a[i]; start streaming a[i+1..n-1]
        cur_nxt   = rdata;
        j_nxt     = i_inc;
        raddr     = i_inc[AW-1:0];
        state_nxt = (i_inc < n_r) ? ST_CMP : ST_EMIT;
      end
      ST_CMP: begin
        raddr = j_inc[AW-1:0];
        // swap only on strictly greater address
        if (cur_r.addr > rdata.addr) begin
          we      = 1'b1;
          waddr   = j_r[AW-1:0];
          wdata   = cur_r;
          cur_nxt = rdata;
        end
        if (j_inc < n_r) begin
          j_nxt = j_inc;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (is_last) begin
          clr       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_RD_I;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      empty_r <= empty_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    n_r   <= n_nxt;
    cur_r <= cur_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_EMIT);

  always_comb begin
    res.entry = cur_r;
    res.total = TOTAL_W'(n_r);
    res.last  = is_last;
    res.empty = empty_r;
  end

endmodule

`default_nettype wire

@@ sv/memory_map_to_e820_table.sv @@
// ============================================================================
// memory_map_to_e820_table
// Folds UEFI memory descriptors into an E820 table; a finish transaction
// sorts the table by address, emits it and clears it.
// ============================================================================
// Add transactions leave busy low, so descriptors can be issued on every
// clock while no finish runs. A finish transaction keeps busy high while the
// exchange sort streams the table through the single read port of the entry
// memory, one compare per cycle, and each pass ends with one result.
// Results come out on consecutive passes, one out_valid cycle each, with
// out_last on the final one; the receiver has no way to stall them.
// ============================================================================
`default_nettype none

module memory_map_to_e820_table
  import e820_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_mem_type,
  input  wire logic [63:0] in_phys_start,
  input  wire logic [63:0] in_page_count,
  output logic             out_valid,
  output logic [63:0]      out_entry_address,
  output logic [63:0]      out_entry_length,
  output logic [2:0]       out_entry_class,
  output logic [5:0]       out_entry_total,
  output logic             out_last,
  output logic             out_empty_res,
  output logic             out_overflow
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

  // intake state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   run_end_r, run_end_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          dropped_r, dropped_nxt;
  e820_entry_t   last_r, last_nxt;

  logic          add_go, fin_go;
  logic [2:0]    cls;
  logic [63:0]   bytes;
  logic          merge;
  logic [CW-1:0] cnt_m1;

  logic          in_we;
  logic [AW-1:0] in_waddr;
  e820_entry_t   in_wdata;

  logic          srt_busy, srt_we, srt_clr, res_valid;
  logic [AW-1:0] srt_waddr, raddr;
  e820_entry_t   srt_wdata, rdata;
  e820_res_t     res;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  e820_entry_t   mem_wdata;

  assign busy   = srt_busy;
  assign add_go = start && !srt_busy && !in_cmd;
  assign fin_go = start && !srt_busy && in_cmd;

  assign cls    = e820_class(in_mem_type);
  assign bytes  = in_page_count << PAGE_SHIFT;
  assign cnt_m1 = cnt_r - 1'b1;
  assign merge  = have_prev_r && (cnt_r != '0) && (last_r.cls == cls) &&
                  (in_phys_start == run_end_r);

  // descriptor intake: merge into the last entry, append, or drop; clear after a finish
  always_comb begin
    cnt_nxt       = cnt_r;
    run_end_nxt   = run_end_r;
    have_prev_nxt = have_prev_r;
    dropped_nxt   = dropped_r;
    last_nxt      = last_r;
    in_we         = 1'b0;
    in_waddr      = cnt_r[AW-1:0];
    in_wdata      = last_r;
    if (srt_clr) begin
      cnt_nxt       = '0;
      run_end_nxt   = '0;
      have_prev_nxt = 1'b0;
      dropped_nxt   = 1'b0;
    end else if (add_go && (cls != CLS_NONE)) begin
      priority if (merge) begin
        last_nxt.len = last_r.len + bytes;
        run_end_nxt  = run_end_r + bytes;
        in_we        = 1'b1;
        in_waddr     = cnt_m1[AW-1:0];
        in_wdata     = last_nxt;
      end else if (cnt_r >= MAX_C) begin
        dropped_nxt = 1'b1;
      end else begin
        last_nxt.addr = in_phys_start;
        last_nxt.len  = bytes;
        last_nxt.cls  = cls;
        run_end_nxt   = in_phys_start + bytes;
        have_prev_nxt = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        in_we         = 1'b1;
        in_waddr      = cnt_r[AW-1:0];
        in_wdata      = last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      run_end_r   <= '0;
      have_prev_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      run_end_r   <= run_end_nxt;
      have_prev_r <= have_prev_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  // write port belongs to the sorter while a finish runs
  assign mem_we    = srt_busy ? srt_we    : in_we;
  assign mem_waddr = srt_busy ? srt_waddr : in_waddr;
  assign mem_wdata = srt_busy ? srt_wdata : in_wdata;

  e820_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  e820_sort #(
    .AW (AW),
    .CW (CW)
  ) u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (fin_go),
    .count     (cnt_r),
    .busy      (srt_busy),
    .we        (srt_we),
    .waddr     (srt_waddr),
    .wdata     (srt_wdata),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .clr       (srt_clr)
  );

  // result ports
  assign out_valid         = res_valid;
  assign out_entry_address = res.entry.addr;
  assign out_entry_length  = res.entry.len;
  assign out_entry_class   = res.entry.cls;
  assign out_entry_total   = res.total;
  assign out_last          = res.last;
  assign out_empty_res     = res.empty;
  assign out_overflow      = dropped_r;

endmodule

`default_nettype wire

@@ sv/e820_checker.sv @@
// ============================================================================
// e820_checker
// Port-level checks on the finish run of the E820 table block.
// ============================================================================
`default_nettype none

module e820_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_cmd,
  input wire logic [31:0] in_mem_type,
  input wire logic [63:0] in_phys_start,
  input wire logic [63:0] in_page_count,
  input wire logic        out_valid,
  input wire logic [63:0] out_entry_address,
  input wire logic [63:0] out_entry_length,
  input wire logic [2:0]  out_entry_class,
  input wire logic [5:0]  out_entry_total,
  input wire logic        out_last,
  input wire logic        out_empty_res,
  input wire logic        out_overflow
);

  // results only appear inside a finish run
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside finish run");

  // a finish transaction starts a run
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd) |=> busy)
    else $error("finish did not raise busy");

  // the last result ends the run
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy)
    else $error("busy after last result");

  // an empty table gives one blank, final result
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |->
      (out_last && out_entry_total == 6'd0 && out_entry_class == 3'd0))
    else $error("malformed empty result");

  // a non-empty result carries a nonzero total and a real class
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_res) |->
      (out_entry_total != 6'd0 && out_entry_class != 3'd0))
    else $error("malformed table entry");

endmodule

bind memory_map_to_e820_table e820_checker u_e820_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// E820 table builder testbench
// Drives descriptor and finish transactions through the start/busy handshake,
// predicts every table entry that a finish emits and checks the entries in
// order as they stream out. A short table of directed transactions comes
// first, then random sequences: merge chains, table-filling runs, raw noise
// and empty finishes.
// ============================================================================

module testbench
  import e820_pkg::*;
();

  localparam int TABLE_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 40;
  localparam int WAIT_LIMIT   = 4000;
  localparam int REPORT_LIMIT = 10;

  // Transaction codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // UEFI memory type codes
  localparam logic [31:0] T_RESERVED     = 32'd0;
  localparam logic [31:0] T_LOADER_CODE  = 32'd1;
  localparam logic [31:0] T_LOADER_DATA  = 32'd2;
  localparam logic [31:0] T_BS_CODE      = 32'd3;
  localparam logic [31:0] T_BS_DATA      = 32'd4;
  localparam logic [31:0] T_RT_CODE      = 32'd5;
  localparam logic [31:0] T_RT_DATA      = 32'd6;
  localparam logic [31:0] T_CONVENTIONAL = 32'd7;
  localparam logic [31:0] T_UNUSABLE     = 32'd8;
  localparam logic [31:0] T_ACPI_RECLAIM = 32'd9;
  localparam logic [31:0] T_ACPI_NVS     = 32'd10;
  localparam logic [31:0] T_MMIO         = 32'd11;
  localparam logic [31:0] T_MMIO_PORT    = 32'd12;
  localparam logic [31:0] T_PAL_CODE     = 32'd13;
  localparam logic [31:0] T_PERSISTENT   = 32'd14;
  localparam logic [31:0] T_UNMAPPED     = 32'd15;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Sequence kinds of the random part
  localparam int SEQ_FILL  = 0;
  localparam int SEQ_EMPTY = 1;
  localparam int SEQ_NOISE = 2;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] len;
    logic [2:0]  cls;
    logic [5:0]  total;
    logic        last;
    logic        empty;
    logic        ovf;
  } e820_out_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] mem_type;
    logic [63:0] phys_start;
    logic [63:0] page_count;
    logic        typed;
    e820_out_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [31:0] in_mem_type = '0;
  logic [63:0] in_phys_start = '0;
  logic [63:0] in_page_count = '0;
  logic        out_valid;
  logic [63:0] out_entry_address;
  logic [63:0] out_entry_length;
  logic [2:0]  out_entry_class;
  logic [5:0]  out_entry_total;
  logic        out_last;
  logic        out_empty_res;
  logic        out_overflow;

  // Predicted table state
  logic [63:0] map_addr [TABLE_DEPTH];
  logic [63:0] map_len  [TABLE_DEPTH];
  logic [2:0]  map_cls  [TABLE_DEPTH];
  int          map_count = 0;
  logic [63:0] map_end = '0;
  logic        map_open = 1'b0;
  logic        map_dropped = 1'b0;

  e820_out_t   pending_entries[$];
  int          mismatch_count = 0;
  int          sent_items = 0;
  bit          burst = 1'b0;

  memory_map_to_e820_table #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_mem_type       (in_mem_type),
    .in_phys_start     (in_phys_start),
    .in_page_count     (in_page_count),
    .out_valid         (out_valid),
    .out_entry_address (out_entry_address),
    .out_entry_length  (out_entry_length),
    .out_entry_class   (out_entry_class),
    .out_entry_total   (out_entry_total),
    .out_last          (out_last),
    .out_empty_res     (out_empty_res),
    .out_overflow      (out_overflow)
  );

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // UEFI type to E820 class
  function automatic logic [2:0] class_of_type(input logic [31:0] t);
    case (t)
      T_RESERVED, T_MMIO, T_MMIO_PORT, T_PAL_CODE: return CLS_RESERVED;
      T_LOADER_CODE, T_LOADER_DATA, T_BS_CODE, T_BS_DATA,
      T_RT_CODE, T_RT_DATA, T_CONVENTIONAL, T_PERSISTENT: return CLS_RAM;
      T_UNUSABLE:     return CLS_UNUSABLE;
      T_ACPI_RECLAIM: return CLS_ACPI;
      T_ACPI_NVS:     return CLS_NVS;
      default:        return CLS_NONE;
    endcase
  endfunction

  // Random UEFI type that lands in the given class
  function automatic logic [31:0] type_for_class(input logic [2:0] c);
    logic [31:0] t;
    case (c)
      CLS_RAM: begin
        t = $urandom_range(T_LOADER_CODE, T_UNUSABLE);
        if (t == T_UNUSABLE) t = T_PERSISTENT;
      end
      CLS_RESERVED: begin
        t = $urandom_range(T_ACPI_NVS, T_PAL_CODE);
        if (t == T_ACPI_NVS) t = T_RESERVED;
      end
      CLS_ACPI:     t = T_ACPI_RECLAIM;
      CLS_NVS:      t = T_ACPI_NVS;
      default:      t = T_UNUSABLE;
    endcase
    return t;
  endfunction

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  // Mostly a small pool of page-aligned addresses, so equal addresses occur
  function automatic logic [63:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 64'($urandom_range(0, 63)) << PAGE_SHIFT;
    if (r < 8) return wide_rand();
    if (r == 8) return ALL_ONES - 64'($urandom_range(0, 16'hFFFF));
    return wide_rand() & ~64'hFFF;
  endfunction

  function automatic logic [63:0] pick_pages();
    int r;
    r = $urandom_range(0, 15);
    if (r < 13) return 64'($urandom_range(0, 16));
    if (r < 15) return wide_rand();
    return ALL_ONES - 64'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] unmapped_type();
    logic [31:0] t;
    t = $urandom;
    if (t < T_UNMAPPED) t = T_UNMAPPED + t;
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t add_row(input logic [31:0] t,
                                        input logic [63:0] s, p);
    stim_row_t r;
    r = '0;
    r.cmd        = CMD_ADD;
    r.mem_type   = t;
    r.phys_start = s;
    r.page_count = p;
    return r;
  endfunction

  // Finish row; the descriptor fields are don't-care and get noise
  function automatic stim_row_t finish_row(input logic typed,
                                           input logic [63:0] a, l,
                                           input logic [2:0] c,
                                           input logic [5:0] n,
                                           input logic e);
    stim_row_t r;
    r = add_row($urandom, wide_rand(), wide_rand());
    r.cmd        = CMD_FINISH;
    r.typed      = typed;
    r.want.addr  = a;
    r.want.len   = l;
    r.want.cls   = c;
    r.want.total = n;
    r.want.last  = 1'b1;
    r.want.empty = e;
    r.want.ovf   = 1'b0;
    return r;
  endfunction

  // Descriptor that continues the last entry when there is one
  function automatic stim_row_t chained_add();
    if (map_open && map_count > 0)
      return add_row(type_for_class(map_cls[map_count-1]), map_end, pick_pages());
    return add_row($urandom_range(T_RESERVED, T_PERSISTENT), pick_addr(), pick_pages());
  endfunction

  // Fold one descriptor into the predicted table
  task automatic fold_descriptor(input stim_row_t r);
    logic [2:0]  c;
    logic [63:0] bytes;
    c = class_of_type(r.mem_type);
    bytes = r.page_count << PAGE_SHIFT;
    if (c == CLS_NONE) return;
    if (map_open && map_count > 0 && map_cls[map_count-1] == c &&
        r.phys_start == map_end) begin
      map_len[map_count-1] = map_len[map_count-1] + bytes;
      map_end = map_end + bytes;
    end else if (map_count >= TABLE_DEPTH) begin
      map_dropped = 1'b1;
    end else begin
      map_addr[map_count] = r.phys_start;
      map_len[map_count]  = bytes;
      map_cls[map_count]  = c;
      map_end  = r.phys_start + bytes;
      map_open = 1'b1;
      map_count++;
    end
  endtask

  // Sort, queue the expected entries and clear the predicted table
  task automatic close_table(input stim_row_t r);
    e820_out_t   res;
    logic [63:0] ta, tl;
    logic [2:0]  tc;
    if (r.typed) begin
      pending_entries.push_back(r.want);
    end else if (map_count == 0) begin
      res = '0;
      res.last  = 1'b1;
      res.empty = 1'b1;
      res.ovf   = map_dropped;
      pending_entries.push_back(res);
    end else begin
      // exchange sort, swapping only on a strictly greater address
      for (int i = 0; i < map_count; i++)
        for (int j = i + 1; j < map_count; j++)
          if (map_addr[i] > map_addr[j]) begin
            ta = map_addr[i]; tl = map_len[i]; tc = map_cls[i];
            map_addr[i] = map_addr[j]; map_len[i] = map_len[j]; map_cls[i] = map_cls[j];
            map_addr[j] = ta; map_len[j] = tl; map_cls[j] = tc;
          end
      for (int i = 0; i < map_count; i++) begin
        res.addr  = map_addr[i];
        res.len   = map_len[i];
        res.cls   = map_cls[i];
        res.total = 6'(map_count);
        res.last  = (i == map_count - 1);
        res.empty = 1'b0;
        res.ovf   = map_dropped;
        pending_entries.push_back(res);
      end
    end
    map_count   = 0;
    map_end     = '0;
    map_open    = 1'b0;
    map_dropped = 1'b0;
  endtask

  // One transaction: optional hold-off, idle gap, handshake, prediction
  task automatic issue(input stim_row_t r, input bit hold);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (hold || gap != 0) begin
      start <= 1'b0;
      if (hold) begin
        do @(posedge clk); while (pending_entries.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    in_cmd        <= r.cmd;
    in_mem_type   <= r.mem_type;
    in_phys_start <= r.phys_start;
    in_page_count <= r.page_count;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    sent_items++;
    if (r.cmd == CMD_FINISH) close_table(r);
    else fold_descriptor(r);
  endtask

  // Result checker: every strobed entry against the oldest expectation
  always @(posedge clk) begin : result_check
    e820_out_t got, want;
    if (rst_n && out_valid) begin
      got.addr  = out_entry_address;
      got.len   = out_entry_length;
      got.cls   = out_entry_class;
      got.total = out_entry_total;
      got.last  = out_last;
      got.empty = out_empty_res;
      got.ovf   = out_overflow;
      if (pending_entries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected entry: addr=%h len=%h cls=%0d total=%0d last=%b empty=%b ovf=%b",
                   got.addr, got.len, got.cls, got.total, got.last, got.empty, got.ovf);
      end else begin
        want = pending_entries.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("entry mismatch at %0t", $realtime);
            $display("  exp addr=%h len=%h cls=%0d total=%0d last=%b empty=%b ovf=%b",
                     want.addr, want.len, want.cls, want.total, want.last, want.empty,
                     want.ovf);
            $display("  got addr=%h len=%h cls=%0d total=%0d last=%b empty=%b ovf=%b",
                     got.addr, got.len, got.cls, got.total, got.last, got.empty, got.ovf);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t rows [24];
    stim_row_t r;
    int        kind, n, waited;
    bit        hold;

    // directed table
    rows[0]  = finish_row(1'b1, '0, '0, CLS_NONE, 6'd0, 1'b1);
    rows[1]  = add_row(T_CONVENTIONAL, '0, '0);
    rows[2]  = finish_row(1'b1, '0, '0, CLS_RAM, 6'd1, 1'b0);
    rows[3]  = add_row(T_UNUSABLE, ALL_ONES, ALL_ONES);
    rows[4]  = finish_row(1'b1, ALL_ONES, 64'hFFFF_FFFF_FFFF_F000, CLS_UNUSABLE, 6'd1, 1'b0);
    rows[5]  = add_row(T_UNMAPPED, 64'h1000, 64'd1);
    rows[6]  = add_row(32'hFFFF_FFFF, ALL_ONES, ALL_ONES);
    rows[7]  = finish_row(1'b1, '0, '0, CLS_NONE, 6'd0, 1'b1);
    // every mapped type; merges where the start meets the running end
    rows[8]  = add_row(T_LOADER_CODE,  64'h1000,   64'd1);
    rows[9]  = add_row(T_LOADER_DATA,  64'h2000,   64'd2);
    rows[10] = add_row(T_PERSISTENT,   64'h4000,   64'd1);
    rows[11] = add_row(T_RESERVED,     64'h100000, 64'd1);
    rows[12] = add_row(T_MMIO,         64'h101000, 64'd1);
    rows[13] = add_row(T_MMIO_PORT,    64'h102000, 64'd1);
    rows[14] = add_row(T_PAL_CODE,     64'h200000, 64'd1);
    rows[15] = add_row(T_ACPI_RECLAIM, 64'h80000,  64'd4);
    rows[16] = add_row(T_ACPI_NVS,     64'h84000,  64'd1);
    rows[17] = add_row(T_UNUSABLE,     64'h10000,  64'd1);
    rows[18] = add_row(T_BS_CODE,      64'h50000,  64'd2);
    rows[19] = add_row(T_BS_DATA,      64'h52000,  64'd1);
    rows[20] = add_row(T_RT_CODE,      64'h53000,  64'd1);
    rows[21] = add_row(T_RT_DATA,      64'h54000,  64'd1);
    rows[22] = add_row(T_CONVENTIONAL, 64'h0,      64'd1);
    rows[23] = finish_row(1'b0, '0, '0, CLS_NONE, 6'd0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 24; i++) issue(rows[i], 1'b0);

    // random sequences, each closed by a finish
    kind = SEQ_FILL;
    hold = 1'b1;
    while (sent_items < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      case (kind)
        SEQ_FILL: begin
          n = $urandom_range(33, 40);
          for (int i = 0; i < n; i++) begin
            if (map_count >= TABLE_DEPTH && $urandom_range(0, 2) == 0)
              r = chained_add();
            else
              r = add_row($urandom_range(T_RESERVED, T_PERSISTENT),
                          64'($urandom_range(0, 63)) << PAGE_SHIFT,
                          64'($urandom_range(0, 8)));
            issue(r, hold);
            hold = 1'b0;
          end
        end
        SEQ_EMPTY: begin
          n = $urandom_range(0, 2);
          for (int i = 0; i < n; i++) begin
            issue(add_row(unmapped_type(), wide_rand(), wide_rand()), hold);
            hold = 1'b0;
          end
        end
        SEQ_NOISE: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            issue(add_row($urandom, wide_rand(), wide_rand()), hold);
            hold = 1'b0;
          end
        end
        default: begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
              r = chained_add();
            else if (kind < 9)
              r = add_row($urandom_range(T_RESERVED, T_PERSISTENT), pick_addr(),
                          pick_pages());
            else
              r = add_row(unmapped_type(), pick_addr(), pick_pages());
            issue(r, hold);
            hold = 1'b0;
          end
        end
      endcase
      issue(finish_row(1'b0, '0, '0, CLS_NONE, 6'd0, 1'b0), hold);
      kind = $urandom_range(0, 9);
      hold = ($urandom_range(0, 4) == 0);
    end
    start <= 1'b0;

    // let the last table drain
    waited = 0;
    while (pending_entries.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_entries.size() != 0) begin
      mismatch_count += pending_entries.size();
      $display("%0d expected entries never arrived", pending_entries.size());
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/e820_pkg.sv
sv/e820_mem.sv
sv/e820_sort.sv
sv/memory_map_to_e820_table.sv
sv/e820_checker.sv
sim/testbench.sv
